>>> design/lss_pkg.sv
`default_nettype none
package lss_pkg;
  localparam int COORD_W        = 32;
  localparam int STEP_W         = 31;
  localparam int DIR_BITS       = 30;
  localparam int MAG_W          = COORD_W + 1;      // |end - start|
  localparam int SQ_W           = 2 * MAG_W;        // dx^2 + dy^2
  localparam int LEN_W          = MAG_W;            // isqrt result
  localparam int NUM_W          = MAG_W + DIR_BITS + 1;
  localparam int DIR_W          = DIR_BITS + 1;     // |u| <= 2^30
  localparam int PROD_W         = STEP_W + DIR_W;
  localparam int ACC_W          = LEN_W + DIR_BITS + 2;
  localparam int T_W            = LEN_W + 2;
  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_FRAC_BITS  = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } lss_state_t;
endpackage
`default_nettype wire

>>> design/lss_mul.sv
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle.
module lss_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [WA-1:0]    a,
  input  wire logic [WB-1:0]    b,
  output logic                  done,
  output logic [WA+WB-1:0]      p
);
  localparam int CW = $clog2(WB + 1);

  logic [CW-1:0]      cnt_r;
  logic [WA+WB-1:0]   mcand_r;
  logic [WB-1:0]      mplr_r;
  logic [WA+WB-1:0]   p_r;
  logic               done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !go && (cnt_r == CW'(1));
      if (go) begin
        cnt_r   <= CW'(WB);
        mcand_r <= {{WB{1'b0}}, a};
        mplr_r  <= b;
        p_r     <= '0;
      end else if (cnt_r != '0) begin
        if (mplr_r[0]) begin
          p_r <= p_r + mcand_r;
        end
        mcand_r <= mcand_r << 1;
        mplr_r  <= mplr_r >> 1;
        cnt_r   <= cnt_r - CW'(1);
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;
endmodule
`default_nettype wire

>>> design/lss_sqrt.sv
`default_nettype none
// Digit-by-digit integer square root, two radicand bits per cycle.
module lss_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      go,
  input  wire logic [lss_pkg::SQ_W-1:0]  s,
  output logic                           done,
  output logic [lss_pkg::LEN_W-1:0]      root
);
  import lss_pkg::*;

  localparam int CW  = $clog2(LEN_W + 1);
  localparam int RW  = LEN_W + 2;

  logic [CW-1:0]    cnt_r;
  logic [SQ_W-1:0]  s_r;
  logic [RW-1:0]    rem_r;
  logic [LEN_W-1:0] root_r;
  logic             done_r;
  logic [RW+1:0]    rem_ext;
  logic [RW+1:0]    trial;
  logic             fit;

  always_comb begin
    rem_ext = {rem_r, s_r[SQ_W-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    fit     = (rem_ext >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !go && (cnt_r == CW'(1));
      if (go) begin
        cnt_r  <= CW'(LEN_W);
        s_r    <= s;
        rem_r  <= '0;
        root_r <= '0;
      end else if (cnt_r != '0) begin
        if (fit) begin
          rem_r  <= RW'(rem_ext - trial);
          root_r <= {root_r[LEN_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_ext[RW-1:0];
          root_r <= {root_r[LEN_W-2:0], 1'b0};
        end
        s_r   <= s_r << 2;
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

>>> design/lss_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. Quotient must fit DIR_W bits.
module lss_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       go,
  input  wire logic [lss_pkg::NUM_W-1:0]  num,
  input  wire logic [lss_pkg::LEN_W-1:0]  den,
  output logic                            done,
  output logic [lss_pkg::DIR_W-1:0]       quo
);
  import lss_pkg::*;

  localparam int CW = $clog2(DIR_W + 1);

  logic [CW-1:0]    cnt_r;
  logic [LEN_W-1:0] rem_r;
  logic [DIR_W-1:0] low_r;
  logic [DIR_W-1:0] quo_r;
  logic             done_r;
  logic [LEN_W:0]   r2;
  logic             fit;

  always_comb begin
    r2  = {rem_r, low_r[DIR_W-1]};
    fit = (r2 >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !go && (cnt_r == CW'(1));
      if (go) begin
        cnt_r <= CW'(DIR_W);
        rem_r <= num[NUM_W-1 -: LEN_W];
        low_r <= num[DIR_W-1:0];
        quo_r <= '0;
      end else if (cnt_r != '0) begin
        rem_r <= fit ? LEN_W'(r2 - {1'b0, den}) : r2[LEN_W-1:0];
        quo_r <= {quo_r[DIR_W-2:0], fit};
        low_r <= low_r << 1;
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

>>> design/line_segment_sampler.sv
`default_nettype none
// Channel   | Handshake             | Word
// ----------+-----------------------+--------------------------------------------
// input     | start & !busy         | in_start_x/y, in_end_x/y (signed Q16.16)
// result    | out_valid (1 cycle)   | out_point_x/y, out_last_point, out_truncated
// config    | cfg_we                | cfg_wdata = step spacing (unsigned Q15.16)
//
// One segment at a time. The squares, the square root, the two direction
// divides and the step*direction products run in that order, all serial
// units; then one point per cycle, 1 to MAX_POINTS points. busy stays high
// from acceptance until the last point is registered.
// Synchronous active-low reset restores step spacing to 1.0.
// Results cannot be stalled; each point is shown for exactly one cycle.
module line_segment_sampler #(
  parameter int MAX_POINTS = lss_pkg::DEF_MAX_POINTS,
  parameter int FRAC_BITS  = lss_pkg::DEF_FRAC_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [lss_pkg::COORD_W-1:0] in_start_x,
  input  wire logic signed [lss_pkg::COORD_W-1:0] in_start_y,
  input  wire logic signed [lss_pkg::COORD_W-1:0] in_end_x,
  input  wire logic signed [lss_pkg::COORD_W-1:0] in_end_y,
  output logic                               out_valid,
  output logic signed [lss_pkg::COORD_W-1:0] out_point_x,
  output logic signed [lss_pkg::COORD_W-1:0] out_point_y,
  output logic                               out_last_point,
  output logic                               out_truncated,
  input  wire logic                          cfg_we,
  input  wire logic [lss_pkg::STEP_W-1:0]    cfg_wdata
);
  import lss_pkg::*;

  localparam int CNT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SUM_W = COORD_W + 5;

  lss_state_t state_r, state_nxt;

  logic [STEP_W-1:0]        step_r;
  logic signed [COORD_W-1:0] sx_r, sy_r;
  logic                     negx_r, negy_r;
  logic [ACC_W-1:0]         accx_r, accy_r;
  logic [T_W-1:0]           t_r;
  logic [CNT_W-1:0]         n_r;
  logic                     ov_r, last_r, trunc_r;
  logic [COORD_W-1:0]       px_r, py_r;

  logic accept;
  logic sq_go, sqrt_go, div_go, mul_go, emit_init, emit_en;
  logic sqx_done, sqy_done, sqrt_done, divx_done, divy_done, mulx_done, muly_done;
  logic [T_W-1:0]           t_next;
  logic                     more, at_max, last_now;

  // magnitudes of the segment deltas, taken straight from the ports
  logic signed [MAG_W-1:0] dx, dy;
  logic [MAG_W-1:0]        ax, ay;
  logic [SQ_W-1:0]         qx, qy;
  logic [LEN_W-1:0]        len;
  logic [DIR_W-1:0]        qux, quy, ux, uy;
  logic [PROD_W-1:0]       sux, suy;
  logic [MAG_W-1:0]        ax_r, ay_r;
  logic [STEP_W-1:0]       step_eff;

  assign accept = start & (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    dx = {in_end_x[COORD_W-1], in_end_x} - {in_start_x[COORD_W-1], in_start_x};
    dy = {in_end_y[COORD_W-1], in_end_y} - {in_start_y[COORD_W-1], in_start_y};
    ax = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    ay = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
  end

  assign step_eff = (step_r == '0) ? STEP_W'(1) : step_r;

  // Units
  lss_mul #(.WA(MAG_W), .WB(MAG_W)) u_sqx (
    .clk(clk), .rst_n(rst_n), .go(sq_go), .a(ax), .b(ax), .done(sqx_done), .p(qx));
  lss_mul #(.WA(MAG_W), .WB(MAG_W)) u_sqy (
    .clk(clk), .rst_n(rst_n), .go(sq_go), .a(ay), .b(ay), .done(sqy_done), .p(qy));

  lss_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .go(sqrt_go), .s(qx + qy), .done(sqrt_done), .root(len));

  // |u| = (|d| << 30 + len/2) / len
  logic [NUM_W-1:0] numx, numy;
  assign numx = {1'b0, ax_r, {DIR_BITS{1'b0}}} + NUM_W'(len >> 1);
  assign numy = {1'b0, ay_r, {DIR_BITS{1'b0}}} + NUM_W'(len >> 1);

  lss_div u_divx (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(numx), .den(len),
    .done(divx_done), .quo(qux));
  lss_div u_divy (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(numy), .den(len),
    .done(divy_done), .quo(quy));

  // zero length: direction is zero, only the start point comes out
  assign ux = (len == '0) ? '0 : qux;
  assign uy = (len == '0) ? '0 : quy;

  lss_mul #(.WA(STEP_W), .WB(DIR_W)) u_mulx (
    .clk(clk), .rst_n(rst_n), .go(mul_go), .a(step_eff), .b(ux),
    .done(mulx_done), .p(sux));
  lss_mul #(.WA(STEP_W), .WB(DIR_W)) u_muly (
    .clk(clk), .rst_n(rst_n), .go(mul_go), .a(step_eff), .b(uy),
    .done(muly_done), .p(suy));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start)                  state_nxt = ST_SQ;
      ST_SQ:   if (sqx_done && sqy_done)   state_nxt = ST_SQRT;
      ST_SQRT: if (sqrt_done)              state_nxt = ST_DIV;
      ST_DIV:  if (divx_done && divy_done) state_nxt = ST_MUL;
      ST_MUL:  if (mulx_done && muly_done) state_nxt = ST_EMIT;
      ST_EMIT: if (last_now)               state_nxt = ST_IDLE;
      default:                             state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    sq_go     = 1'b0;
    sqrt_go   = 1'b0;
    div_go    = 1'b0;
    mul_go    = 1'b0;
    emit_init = 1'b0;
    emit_en   = 1'b0;
    case (state_r)
      ST_IDLE: sq_go     = start;
      ST_SQ:   sqrt_go   = sqx_done && sqy_done;
      ST_SQRT: div_go    = sqrt_done;
      ST_DIV:  mul_go    = divx_done && divy_done;
      ST_MUL:  emit_init = mulx_done && muly_done;
      ST_EMIT: emit_en   = 1'b1;
      default: ;
    endcase
  end

  // Point generation: acc = 2^29 + t*|u|, offset = acc >> 30
  logic [ACC_W-DIR_BITS-1:0] offx, offy;
  logic signed [SUM_W-1:0]  sumx, sumy;

  function automatic logic [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi)      sat = hi[COORD_W-1:0];
    else if (v < lo) sat = lo[COORD_W-1:0];
    else             sat = v[COORD_W-1:0];
  endfunction

  always_comb begin
    t_next   = t_r + T_W'(step_eff);
    more     = (t_next <= T_W'(len));
    at_max   = (n_r == CNT_W'(MAX_POINTS - 1));
    last_now = !more || at_max;
    offx     = accx_r[ACC_W-1:DIR_BITS];
    offy     = accy_r[ACC_W-1:DIR_BITS];
    sumx     = negx_r ? SUM_W'(sx_r) - SUM_W'(offx) : SUM_W'(sx_r) + SUM_W'(offx);
    sumy     = negy_r ? SUM_W'(sy_r) - SUM_W'(offy) : SUM_W'(sy_r) + SUM_W'(offy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_W'(1) << FRAC_BITS;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= emit_en;
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sx_r   <= in_start_x;
      sy_r   <= in_start_y;
      negx_r <= dx[MAG_W-1];
      negy_r <= dy[MAG_W-1];
      ax_r   <= ax;
      ay_r   <= ay;
    end
    if (emit_init) begin
      accx_r <= ACC_W'(1) << (DIR_BITS - 1);
      accy_r <= ACC_W'(1) << (DIR_BITS - 1);
      t_r    <= '0;
      n_r    <= '0;
    end else if (emit_en) begin
      accx_r  <= accx_r + ACC_W'(sux);
      accy_r  <= accy_r + ACC_W'(suy);
      t_r     <= t_next;
      n_r     <= n_r + CNT_W'(1);
      px_r    <= sat(sumx);
      py_r    <= sat(sumy);
      last_r  <= last_now;
      trunc_r <= more && at_max;
    end
  end

  assign out_valid      = ov_r;
  assign out_point_x    = px_r;
  assign out_point_y    = py_r;
  assign out_last_point = last_r;
  assign out_truncated  = trunc_r;
endmodule
`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lss_pkg::*;

  localparam int MAX_PTS = DEF_MAX_POINTS;
  localparam int DRAIN_CYC = 300;   // margin for the math plus up to 64 points

  // expected point as seen on the result ports
  typedef struct {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      last;
    logic                      trunc;
  } point_t;

  // one segment of the directed table; pinned rows expect the start point alone
  typedef struct {
    logic signed [COORD_W-1:0] sx, sy, ex, ey;
    bit                        pinned;
  } seg_row_t;

  logic clk, rst_n, start, busy;
  logic signed [COORD_W-1:0] in_start_x, in_start_y, in_end_x, in_end_y;
  logic out_valid, out_last_point, out_truncated;
  logic signed [COORD_W-1:0] out_point_x, out_point_y;
  logic cfg_we;
  logic [STEP_W-1:0] cfg_wdata;

  point_t      pending_pts[$];
  logic [63:0] spacing_q;        // shadow of the step spacing register
  int          err_cnt = 0;

  line_segment_sampler u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_point_x(out_point_x), .out_point_y(out_point_y),
    .out_last_point(out_last_point), .out_truncated(out_truncated),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case words go missing or busy never drops
  initial begin
    #4ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // append one expected point at the tail of the queue
  function automatic void queue_point(point_t pt);
    pending_pts = {pending_pts, pt};
  endfunction

  // start + t*|u| rounded half away from zero, signed by d, clamped to 32 bits
  function automatic logic [COORD_W-1:0] place_coord(longint org, bit neg,
                                                     logic [65:0] u, logic [65:0] t);
    logic [69:0] prod;
    longint      off, p;
    prod = 70'(t) * 70'(u) + (70'd1 << (DIR_BITS - 1));
    off  = longint'(prod >> DIR_BITS);
    p    = neg ? org - off : org + off;
    if (p > 64'sh7FFFFFFF) p = 64'sh7FFFFFFF;
    if (p < -64'sh80000000) p = -64'sh80000000;
    return p[COORD_W-1:0];
  endfunction

  // work out every point of one segment and queue them up
  function automatic void sample_segment(logic signed [COORD_W-1:0] sx, sy, ex, ey);
    longint      dx, dy;
    logic [65:0] ax, ay, sum, len, ux, uy, t, step;
    logic [69:0] root, cand;
    int          n;
    point_t      pt;
    dx  = longint'(ex) - longint'(sx);
    dy  = longint'(ey) - longint'(sy);
    ax  = (dx < 0) ? 66'(-dx) : 66'(dx);
    ay  = (dy < 0) ? 66'(-dy) : 66'(dy);
    sum = ax * ax + ay * ay;
    // bitwise integer square root, floor
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (70'd1 << b);
      if (cand * cand <= 70'(sum)) root = cand;
    end
    len  = root[65:0];
    ux   = '0;
    uy   = '0;
    if (len != 0) begin
      ux = ((ax << DIR_BITS) + len / 2) / len;
      uy = ((ay << DIR_BITS) + len / 2) / len;
    end
    step = (spacing_q == 0) ? 66'd1 : 66'(spacing_q);
    t = '0;
    n = 0;
    while (n < MAX_PTS && t <= len) begin
      pt.px    = place_coord(longint'(sx), dx < 0, ux, t);
      pt.py    = place_coord(longint'(sy), dy < 0, uy, t);
      pt.last  = 1'b0;
      pt.trunc = 1'b0;
      queue_point(pt);
      n++;
      t += step;
    end
    pending_pts[$].last  = 1'b1;
    pending_pts[$].trunc = (n == MAX_PTS) && (t <= len);
  endfunction

  // result checker: every strobed word against the oldest expected point
  always @(posedge clk) begin
    point_t exp_pt;
    if (rst_n && out_valid) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h last=%b trunc=%b", $time,
                 out_point_x, out_point_y, out_last_point, out_truncated);
        err_cnt++;
      end else begin
        exp_pt = pending_pts.pop_front();
        if (out_point_x !== exp_pt.px) begin
          $display("%0t: point_x expected %h actual %h", $time, exp_pt.px, out_point_x);
          err_cnt++;
        end
        if (out_point_y !== exp_pt.py) begin
          $display("%0t: point_y expected %h actual %h", $time, exp_pt.py, out_point_y);
          err_cnt++;
        end
        if (out_last_point !== exp_pt.last) begin
          $display("%0t: last_point expected %b actual %b", $time, exp_pt.last,
                   out_last_point);
          err_cnt++;
        end
        if (out_truncated !== exp_pt.trunc) begin
          $display("%0t: truncated expected %b actual %b", $time, exp_pt.trunc,
                   out_truncated);
          err_cnt++;
        end
      end
    end
  end

  // mostly back-to-back, sometimes a few cycles, rarely a long pause
  task automatic idle_gap();
    int r, len;
    r = $urandom_range(99);
    len = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(20, 60);
    if (len > 0) begin
      start = 1'b0;
      repeat (len) @(negedge clk);
    end
  endtask

  // present a segment from a falling edge and hold it until taken
  task automatic send_segment(logic signed [COORD_W-1:0] sx, sy, ex, ey,
                              bit pinned = 1'b0);
    point_t pt;
    start      = 1'b1;
    in_start_x = sx;
    in_start_y = sy;
    in_end_x   = ex;
    in_end_y   = ey;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (pinned) begin
      // zero-length: the start point alone, marked last
      pt.px = sx;
      pt.py = sy;
      pt.last = 1'b1;
      pt.trunc = 1'b0;
      queue_point(pt);
    end else begin
      sample_segment(sx, sy, ex, ey);
    end
    @(negedge clk);
    idle_gap();
  endtask

  // drain everything, let the engine settle, then change the spacing
  task automatic set_spacing(logic [STEP_W-1:0] val);
    start = 1'b0;
    while (pending_pts.size() != 0 || busy) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    spacing_q = 64'(val);
  endtask

  function automatic logic signed [COORD_W-1:0] clamp32(longint v);
    if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
    if (v < -64'sh80000000) v = -64'sh80000000;
    return v[COORD_W-1:0];
  endfunction

  // random segment: mostly sized to span up to 70 steps on each axis at the current
  // spacing, the rest fully random coordinates
  task automatic random_segment();
    logic signed [COORD_W-1:0] sx, sy;
    longint span, dx, dy;
    sx = $urandom;
    sy = $urandom;
    if ($urandom_range(99) < 75) begin
      span = longint'(spacing_q) * $urandom_range(0, 70);
      if (span == 0) span = $urandom_range(0, 3);
      dx = longint'($urandom_range(0, 1000)) * span / 1000;
      dy = longint'($urandom_range(0, 1000)) * span / 1000;
      if ($urandom_range(1)) dx = -dx;
      if ($urandom_range(1)) dy = -dy;
      if ($urandom_range(9) == 0) dy = 0;
      send_segment(sx, sy, clamp32(longint'(sx) + dx), clamp32(longint'(sy) + dy));
    end else begin
      send_segment(sx, sy, $urandom, $urandom);
    end
  endtask

  localparam logic signed [31:0] PMAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] PMIN = 32'sh80000000;

  seg_row_t dir_rows[] = '{
    '{32'sh0,        32'sh0,        32'sh0,        32'sh0,        1'b1},
    '{PMAX,          PMAX,          PMAX,          PMAX,          1'b1},
    '{PMIN,          PMIN,          PMIN,          PMIN,          1'b1},
    '{32'sh12345,    -32'sh6789A,   32'sh12345,    -32'sh6789A,   1'b1},
    '{32'sh0,        32'sh0,        32'sh000A0000, 32'sh0,        1'b0},
    '{32'sh0,        32'sh0,        32'sh0,        -32'sh000A0000, 1'b0},
    '{32'sh00010000, 32'sh00020000, -32'sh00030000, -32'sh00050000, 1'b0},
    '{32'sh0,        32'sh0,        32'sh00030000, 32'sh00040000, 1'b0},
    '{32'sh0,        32'sh0,        32'sh003F0000, 32'sh0,        1'b0},
    '{32'sh0,        32'sh0,        32'sh00400000, 32'sh0,        1'b0},
    '{32'sh0,        32'sh0,        32'sh00640000, 32'sh0,        1'b0},
    '{PMIN,          PMIN,          PMAX,          PMAX,          1'b0},
    '{PMAX,          PMIN,          PMIN,          PMAX,          1'b0},
    '{32'sh7FFFFFF0, 32'sh0,        PMAX,          32'sh0,        1'b0},
    '{PMIN,          32'sh0,        32'sh80000005, 32'sh3,        1'b0},
    '{32'sh0,        32'sh0,        32'sh0,        32'sh1,        1'b0},
    '{32'sh0,        32'sh0,        32'sh1,        32'sh1,        1'b0},
    '{-32'sh00001000, 32'sh7FFF0000, 32'sh00020000, PMAX,         1'b0}
  };

  initial begin
    logic [STEP_W-1:0] phase_step[4];
    start = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_start_x = '0;
    in_start_y = '0;
    in_end_x = '0;
    in_end_y = '0;
    spacing_q = 64'd1 << DEF_FRAC_BITS;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed pass at the reset spacing of 1.0
    foreach (dir_rows[i])
      send_segment(dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex, dir_rows[i].ey,
                   dir_rows[i].pinned);

    // random passes: smallest spacing, largest, 1.5, then a random one
    phase_step[0] = 31'd1;
    phase_step[1] = 31'h7FFFFFFF;
    phase_step[2] = 31'h00018000;
    phase_step[3] = 31'($urandom_range(1, 32'h7FFFFFFF));
    for (int ph = 0; ph < 4; ph++) begin
      set_spacing(phase_step[ph]);
      // tiny step: two hand-sized segments too
      if (ph == 0) begin
        send_segment(32'sh0, 32'sh0, 32'sh3F, 32'sh0);
        send_segment(32'sh0, 32'sh0, 32'sh40, 32'sh0);
      end
      repeat (38) random_segment();
    end
    set_spacing(31'h00010000);
    repeat (10) random_segment();

    start = 1'b0;
    while (pending_pts.size() != 0 || busy) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
